// ===== hdl/epm_pkg.sv =====
// ----------------------------------------------------------------------------
// Entropy pool mixer package
// Word width, mixing constants and the mixing step shared by the design.
// ----------------------------------------------------------------------------
`default_nettype none

package epm_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned IndexW  = 5;
  localparam int unsigned ShiftLo = 7;
  localparam int unsigned ShiftHi = 25;

  localparam logic [WordW-1:0] MixConst = 32'h9e37_79b9;

  typedef logic [WordW-1:0] word_t;

  // One chained mixing step; every term uses the old chain value.
  function automatic word_t mix_step(input word_t u, input word_t p);
    word_t t;
    t = (u ^ p) + MixConst;
    return t ^ (u << ShiftLo) ^ (u >> ShiftHi);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/entropy_pool_mixer_core.sv =====
// ----------------------------------------------------------------------------
// Entropy pool mixer core
// Adds each input word into a pool held in a synchronous RAM and, when the
// pool fills, runs a chained mixing pass over every word in order.
// ----------------------------------------------------------------------------
// A plain add captures the input word in S_IDLE and loads the result register
// in S_ADD once the output is free; a new word is taken only back in S_IDLE.
// The filling word adds a mixing pass, one RAM read-modify-write per word.
// Reset: synchronous; clears the position, the FSM, the output valid and the
// per-word valid bits, so that every pool word reads as zero until written.
`default_nettype none

module entropy_pool_mixer_core #(
  parameter int unsigned POOL_WORDS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [epm_pkg::WordW-1:0]  entropy_word,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [epm_pkg::WordW-1:0]       pool_word,
  output logic [epm_pkg::IndexW-1:0]      word_index,
  output logic                            mixed,
  output logic                            last
);

  localparam int unsigned IdxW = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(POOL_WORDS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_MIX
  } state_t;

  state_t state;

  logic [IdxW-1:0]      position;
  logic [IdxW-1:0]      mix_idx;
  epm_pkg::word_t       in_word;
  epm_pkg::word_t       chain;

  // Pool RAM with registered read data and per-word valid bits.
  epm_pkg::word_t       mem [POOL_WORDS];
  logic [POOL_WORDS-1:0] vld;
  epm_pkg::word_t       rdata;
  logic                 rd_vld;

  logic                 re;
  logic [IdxW-1:0]      raddr;
  logic                 we;
  logic [IdxW-1:0]      waddr;
  epm_pkg::word_t       wdata;

  logic                 out_free;
  logic                 out_load;
  epm_pkg::word_t       rd_word;
  epm_pkg::word_t       sum;
  epm_pkg::word_t       u_next;
  logic                 add_go;
  logic                 mix_go;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign rd_word  = rd_vld ? rdata : '0;
  assign sum      = rd_word + in_word;
  assign u_next   = epm_pkg::mix_step(chain, rd_word);

  // The filling add needs no output slot; a plain add and a mix step do.
  assign add_go = (state == S_ADD) && ((position == LastIdx) || out_free);
  assign mix_go = (state == S_MIX) && out_free;

  // A new result beat is loaded by a plain add or by any mix step.
  assign out_load = (add_go && (position != LastIdx)) || mix_go;

  // RAM port control.
  always_comb begin
    re    = 1'b0;
    raddr = position;
    we    = 1'b0;
    waddr = position;
    wdata = sum;
    if (state == S_IDLE && in_valid) begin
      re = 1'b1;
    end
    if (add_go) begin
      we = 1'b1;
      if (position == LastIdx) begin
        re    = 1'b1;
        raddr = '0;
      end
    end
    if (mix_go) begin
      we    = 1'b1;
      waddr = mix_idx;
      wdata = u_next;
      if (mix_idx != LastIdx) begin
        re    = 1'b1;
        raddr = mix_idx + 1'b1;
      end
    end
  end

  // Pool memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Valid bits: a word never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (re) begin
        rd_vld <= vld[raddr];
      end
      if (we) begin
        vld[waddr] <= 1'b1;
      end
    end
  end

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      position  <= '0;
      mix_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_word <= entropy_word;
            state   <= S_ADD;
          end
        end
        S_ADD: begin
          if (add_go) begin
            if (position == LastIdx) begin
              chain   <= in_word;
              mix_idx <= '0;
              state   <= S_MIX;
            end else begin
              pool_word  <= sum;
              word_index <= epm_pkg::IndexW'(position);
              mixed      <= 1'b0;
              last       <= 1'b1;
              position   <= position + 1'b1;
              state      <= S_IDLE;
            end
          end
        end
        S_MIX: begin
          if (mix_go) begin
            pool_word  <= u_next;
            word_index <= epm_pkg::IndexW'(mix_idx);
            mixed      <= 1'b1;
            last       <= (mix_idx == LastIdx);
            chain      <= u_next;
            mix_idx    <= mix_idx + 1'b1;
            if (mix_idx == LastIdx) begin
              position <= '0;
              state    <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The RAM never sees a read and a write of the same word in one cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (we && re) |-> (waddr != raddr))
    else $error("RAM read and write collide on one address");

  // After an input beat the core does add work and is not ready in the cycle after it.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is still in work");

  // A plain add result is always the only and final result of its input.
  a_plain_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !mixed) |-> last)
    else $error("plain add result without last");

  // Inside a mixing pass the next result follows a taken beat at once.
  a_mix_streams: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && mixed && !last) |=> out_valid)
    else $error("mixing pass stalled with a free output register");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Entropy pool mixer core testbench
// Drives entropy words into the core with random handshake gaps and checks
// every result beat against a cycle-free model of the pool: plain adds, the
// chained mixing pass on every filling word, the index wrap and the last flag.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PoolN     = 32;
  localparam int unsigned GapMax    = 13;
  localparam int unsigned LongHold  = 300;
  localparam int unsigned TailWait  = 40;
  localparam int unsigned StallLimit = 2000;

  // One expected result beat.
  typedef struct packed {
    epm_pkg::word_t              word;
    logic [epm_pkg::IndexW-1:0]  idx;
    logic                        mixed;
    logic                        last;
  } pool_result_t;

  // Pool image, expected beats and mismatch bookkeeping.
  class pool_scoreboard;
    epm_pkg::word_t pool_img[PoolN];
    int unsigned    wr_pos;
    pool_result_t   due_q[$];
    int unsigned    fail_count;
    int unsigned    words_in;
    int unsigned    beats_out;
    int unsigned    mix_passes;

    function new();
      foreach (pool_img[i]) pool_img[i] = '0;
      wr_pos     = 0;
      fail_count = 0;
      words_in   = 0;
      beats_out  = 0;
      mix_passes = 0;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    // Adds an accepted word into the pool image and queues the beats it causes.
    function void note_word(input epm_pkg::word_t w);
      pool_result_t   r;
      epm_pkg::word_t u;
      int unsigned    k;
      words_in++;
      pool_img[wr_pos] = pool_img[wr_pos] + w;
      if (wr_pos != PoolN - 1) begin
        r.word  = pool_img[wr_pos];
        r.idx   = wr_pos[epm_pkg::IndexW-1:0];
        r.mixed = 1'b0;
        r.last  = 1'b1;
        due_q.push_back(r);
        wr_pos++;
      end else begin
        // The filling word starts the chain; each step sees the old chain value.
        u = w;
        for (k = 0; k < PoolN; k++) begin
          u = ((u ^ pool_img[k]) + epm_pkg::MixConst) ^ (u << epm_pkg::ShiftLo)
              ^ (u >> epm_pkg::ShiftHi);
          pool_img[k] = u;
          r.word  = u;
          r.idx   = k[epm_pkg::IndexW-1:0];
          r.mixed = 1'b1;
          r.last  = (k == PoolN - 1);
          due_q.push_back(r);
        end
        wr_pos = 0;
        mix_passes++;
      end
    endfunction

    task report(input string msg);
      $display("MISMATCH at %0t: %0s", $realtime, msg);
      fail_count++;
    endtask

    // Compares one output beat with the oldest expected beat.
    task check_result(input epm_pkg::word_t word, input logic [epm_pkg::IndexW-1:0] idx,
                      input logic mx, input logic lst);
      pool_result_t e;
      beats_out++;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected beat: word %08h index %0d", word, idx));
        return;
      end
      e = due_q.pop_front();
      if (word !== e.word)
        report($sformatf("pool_word %08h, want %08h (index %0d)", word, e.word, e.idx));
      if (idx !== e.idx)
        report($sformatf("word_index %0d, want %0d", idx, e.idx));
      if (mx !== e.mixed)
        report($sformatf("mixed %0b, want %0b (index %0d)", mx, e.mixed, e.idx));
      if (lst !== e.last)
        report($sformatf("last %0b, want %0b (index %0d)", lst, e.last, e.idx));
    endtask
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  epm_pkg::word_t              entropy_word = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  epm_pkg::word_t              pool_word;
  logic [epm_pkg::IndexW-1:0]  word_index;
  logic                        mixed;
  logic                        last;

  pool_scoreboard       sb;
  bit                   tx_idle = 1'b1;
  bit                   rx_idle = 1'b1;
  bit                   long_hold_req = 1'b0;
  int unsigned          quiet_cycles = 0;

  entropy_pool_mixer_core #(
    .POOL_WORDS(PoolN)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .entropy_word(entropy_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pool_word   (pool_word),
    .word_index  (word_index),
    .mixed       (mixed),
    .last        (last)
  );

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  // Output monitor and stall watchdog.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(pool_word, word_index, mixed, last);
    end
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Watchdog: no beat for %0d cycles, %0d results still due",
               StallLimit, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random hold-offs per beat, plus one long hold on request.
  initial begin : rx_drive
    int unsigned gap;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        long_hold_req = 1'b0;
      end
      gap = rx_idle ? $urandom_range(0, GapMax) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Offers one word, after a random gap when idling is on, and waits until it is taken.
  task automatic send_word(input epm_pkg::word_t w);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, GapMax) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    entropy_word <= w;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_word(w);
  endtask

  // Drops valid and waits until every expected beat has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random word, biased toward all-zero, all-one and single-bit patterns.
  function automatic epm_pkg::word_t pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return epm_pkg::word_t'(1) << $urandom_range(0, epm_pkg::WordW - 1);
      3: return ~(epm_pkg::word_t'(1) << $urandom_range(0, epm_pkg::WordW - 1));
      default: return $urandom();
    endcase
  endfunction

  // Stimulus sequence.
  initial begin : stimulus
    epm_pkg::word_t directed[20];
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed words: extremes, carries and the mixing constant itself.
    directed = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
                 32'h7fff_ffff, 32'haaaa_aaaa, 32'h5555_5555, 32'h9e37_79b9,
                 32'h61c8_8647, 32'hffff_ff80, 32'h01ff_ffff, 32'hfe00_0000,
                 32'h0000_007f, 32'h8000_0001, 32'hffff_fffe, 32'h1234_5678,
                 32'hdead_beef, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'hffff_ffff};
    foreach (directed[i]) send_word(directed[i]);
    drain_results();

    // Back-to-back stretch with no idling on either side.
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (60) send_word(pick_word());
    drain_results();

    // Long output hold while words keep coming, so the input must stall.
    long_hold_req = 1'b1;
    repeat (40) send_word(pick_word());
    drain_results();

    // Random idling on both sides for the bulk of the run.
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (210) send_word(pick_word());
    drain_results();

    repeat (TailWait) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Run covered %0d input beats and %0d result beats, %0d full mixing passes,",
             sb.words_in, sb.beats_out, sb.mix_passes);
    $display("with back-to-back traffic, random gaps, a long output hold and drains.");
    if (sb.fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
